// ===== sv/trd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg: shared definitions of the telnet receive deframer
// Byte codes, result kinds, parser states, register map and the record
// type that the front end hands to the output sequencer.
// ----------------------------------------------------------------------------
package trd_pkg;

    // Widths fixed by the byte stream and the result fields
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Defaults for top level parameters
    localparam int SUB_LIMIT_DEF = 128;
    localparam int QDEPTH_DEF    = 4;

    // Telnet byte codes
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CMD_EOF  = 8'd236;
    localparam logic [BYTE_W-1:0] CMD_SUSP = 8'd237;
    localparam logic [BYTE_W-1:0] CMD_ABRT = 8'd238;
    localparam logic [BYTE_W-1:0] CMD_EOR  = 8'd239;
    localparam logic [BYTE_W-1:0] CMD_SE   = 8'd240;
    localparam logic [BYTE_W-1:0] CMD_DM   = 8'd242;
    localparam logic [BYTE_W-1:0] CMD_BRK  = 8'd243;
    localparam logic [BYTE_W-1:0] CMD_IP   = 8'd244;
    localparam logic [BYTE_W-1:0] CMD_AO   = 8'd245;
    localparam logic [BYTE_W-1:0] CMD_AYT  = 8'd246;
    localparam logic [BYTE_W-1:0] CMD_EC   = 8'd247;
    localparam logic [BYTE_W-1:0] CMD_EL   = 8'd248;
    localparam logic [BYTE_W-1:0] CMD_SB   = 8'd250;
    localparam logic [BYTE_W-1:0] CMD_WILL = 8'd251;
    localparam logic [BYTE_W-1:0] CMD_WONT = 8'd252;
    localparam logic [BYTE_W-1:0] CMD_DO   = 8'd253;
    localparam logic [BYTE_W-1:0] CMD_DONT = 8'd254;
    localparam logic [BYTE_W-1:0] CMD_IAC  = 8'd255;
    localparam logic [BYTE_W-1:0] CHAR_NONE = 8'd255;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_PEER_BINARY = 3'd0;
    localparam logic [2:0] REG_LINE_MODE   = 3'd1;
    localparam logic [2:0] REG_PEER_EOR    = 3'd2;
    localparam logic [2:0] REG_ABORT_CHAR  = 3'd3;
    localparam logic [2:0] REG_ERASE_CHAR  = 3'd4;
    localparam logic [2:0] REG_KILL_CHAR   = 3'd5;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA    = 4'd0,
        KIND_IP      = 4'd1,
        KIND_BREAK   = 4'd2,
        KIND_AYT     = 4'd3,
        KIND_AO      = 4'd4,
        KIND_DM      = 4'd5,
        KIND_EOF     = 4'd6,
        KIND_SUSP    = 4'd7,
        KIND_WILL    = 4'd8,
        KIND_WONT    = 4'd9,
        KIND_DO      = 4'd10,
        KIND_DONT    = 4'd11,
        KIND_SUBBYTE = 4'd12,
        KIND_SUBEND  = 4'd13
    } t_kind;

    // Parser states, one-hot
    typedef enum logic [9:0] {
        ST_DATA = 10'b00_0000_0001,
        ST_IAC  = 10'b00_0000_0010,
        ST_CR   = 10'b00_0000_0100,
        ST_SB   = 10'b00_0000_1000,
        ST_SE   = 10'b00_0001_0000,
        ST_WILL = 10'b00_0010_0000,
        ST_WONT = 10'b00_0100_0000,
        ST_DO   = 10'b00_1000_0000,
        ST_DONT = 10'b01_0000_0000,
        ST_HELD = 10'b10_0000_0000
    } t_state;

    // Configuration seen by the parser
    typedef struct packed {
        logic              peer_binary;
        logic              line_mode;
        logic              peer_eor;
        logic [BYTE_W-1:0] abort_char;
        logic [BYTE_W-1:0] erase_char;
        logic [BYTE_W-1:0] kill_char;
    } t_cfg;

    // One result
    typedef struct packed {
        logic              vld;
        t_kind             kind;
        logic [BYTE_W-1:0] val;
    } t_res;

    // Results of one input byte (one or two)
    typedef struct packed {
        logic              two;
        t_kind             kind0;
        logic [BYTE_W-1:0] val0;
        t_kind             kind1;
        logic [BYTE_W-1:0] val1;
    } t_rec;

endpackage

// ===== sv/telnet_receive_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_deframer: telnet receive stream parser
// Splits received network bytes into terminal data and telnet events.
//
//   Channel  | Ports                                  | Transaction
//   ---------+----------------------------------------+--------------------
//   input    | i_rx_byte, push, full                  | push & ~full
//   result   | o_kind, o_value, o_last, pop, empty    | pop & ~empty
//   config   | psel, penable, pwrite, paddr, pwdata,  | psel & penable &
//            | prdata, pready                         | pwrite & pready
//
// One byte is accepted per cycle unless full; the parser steps once per byte.
// The output sequencer gives one result per cycle while pop is high and not
// empty, so a byte with two results is given out as two; the queue absorbs that.
// full rises only when the record queue (QDEPTH entries) fills up.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module telnet_receive_deframer
    import trd_pkg::*;
#(
    parameter int SUB_LIMIT = SUB_LIMIT_DEF,
    parameter int QDEPTH    = QDEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input bytes
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // results
    input  logic              pop,
    output logic              empty,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_value,
    output logic              o_last,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg cfg;
    t_rec fr_rec, q_rec;
    logic fr_vld, q_full, q_empty, q_rd, accept;

    // accept a byte whenever the record queue has room
    assign full   = q_full;
    assign accept = push & ~q_full;

    trd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    trd_front #(
        .SUB_LIMIT (SUB_LIMIT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_rec_vld (fr_vld),
        .o_rec     (fr_rec)
    );

    trd_queue #(
        .QDEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fr_vld),
        .i_wdata (fr_rec),
        .i_rd    (q_rd),
        .o_rdata (q_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    trd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (q_rec),
        .i_rec_empty (q_empty),
        .o_rec_rd    (q_rd),
        .pop         (pop),
        .empty       (empty),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_last      (o_last)
    );

endmodule

// ===== sv/trd_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_cfg: configuration registers
// APB-style register file holding the binary, line mode and EOR flags and
// the characters inserted for abort output, erase character and erase line.
// ----------------------------------------------------------------------------
module trd_cfg
    import trd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.peer_binary <= 1'b0;
            r_cfg.line_mode   <= 1'b0;
            r_cfg.peer_eor    <= 1'b0;
            r_cfg.abort_char  <= CHAR_NONE;
            r_cfg.erase_char  <= CHAR_NONE;
            r_cfg.kill_char   <= CHAR_NONE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PEER_BINARY: r_cfg.peer_binary <= pwdata[0];
                REG_LINE_MODE:   r_cfg.line_mode   <= pwdata[0];
                REG_PEER_EOR:    r_cfg.peer_eor    <= pwdata[0];
                REG_ABORT_CHAR:  r_cfg.abort_char  <= pwdata[BYTE_W-1:0];
                REG_ERASE_CHAR:  r_cfg.erase_char  <= pwdata[BYTE_W-1:0];
                REG_KILL_CHAR:   r_cfg.kill_char   <= pwdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_PEER_BINARY: prdata[0] = r_cfg.peer_binary;
            REG_LINE_MODE:   prdata[0] = r_cfg.line_mode;
            REG_PEER_EOR:    prdata[0] = r_cfg.peer_eor;
            REG_ABORT_CHAR:  prdata[BYTE_W-1:0] = r_cfg.abort_char;
            REG_ERASE_CHAR:  prdata[BYTE_W-1:0] = r_cfg.erase_char;
            REG_KILL_CHAR:   prdata[BYTE_W-1:0] = r_cfg.kill_char;
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== sv/trd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_front: telnet byte parser
// Accepts one received byte per cycle while i_accept is high, walks the telnet
// state machine and packs the one or two results that the byte causes into a record.
// ----------------------------------------------------------------------------
module trd_front
    import trd_pkg::*;
#(
    parameter int SUB_LIMIT = SUB_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_rec_vld,
    output t_rec              o_rec
);

    localparam logic [BYTE_W-1:0] SubMax = BYTE_W'(SUB_LIMIT);

    typedef struct packed {
        t_res   res;
        t_state nxt;
        logic   sub_clr;
    } t_step;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_sub_cnt, n_sub_cnt;
    t_res              res0, res1;

    // Byte in the data state
    function automatic t_step plain_step(input logic [BYTE_W-1:0] c, input t_cfg cfg);
        t_step s;
        s.res     = '{vld: 1'b1, kind: KIND_DATA, val: c};
        s.nxt     = ST_DATA;
        s.sub_clr = 1'b0;
        if (c == CMD_IAC) begin
            s.res.vld = 1'b0;
            s.nxt     = ST_IAC;
        end else if (c == CH_CR && !cfg.peer_binary) begin
            if (cfg.line_mode) begin
                s.res.vld = 1'b0;
                s.nxt     = ST_HELD;
            end else begin
                s.nxt = ST_CR;
            end
        end
        return s;
    endfunction

    // Byte following IAC
    function automatic t_step cmd_step(input logic [BYTE_W-1:0] c, input t_cfg cfg);
        t_step s;
        s.res     = '{vld: 1'b1, kind: KIND_DATA, val: '0};
        s.nxt     = ST_DATA;
        s.sub_clr = 1'b0;
        case (c)
            CMD_IP:   s.res.kind = KIND_IP;
            CMD_BRK,
            CMD_ABRT: s.res.kind = KIND_BREAK;
            CMD_AYT:  s.res.kind = KIND_AYT;
            CMD_AO: begin
                s.res.kind = KIND_AO;
                s.res.val  = cfg.abort_char;
            end
            CMD_EC: begin
                s.res.vld = (cfg.erase_char != CHAR_NONE);
                s.res.val = cfg.erase_char;
            end
            CMD_EL: begin
                s.res.vld = (cfg.kill_char != CHAR_NONE);
                s.res.val = cfg.kill_char;
            end
            CMD_DM:   s.res.kind = KIND_DM;
            CMD_SB: begin
                s.res.vld = 1'b0;
                s.nxt     = ST_SB;
                s.sub_clr = 1'b1;
            end
            CMD_WILL: begin
                s.res.vld = 1'b0;
                s.nxt     = ST_WILL;
            end
            CMD_WONT: begin
                s.res.vld = 1'b0;
                s.nxt     = ST_WONT;
            end
            CMD_DO: begin
                s.res.vld = 1'b0;
                s.nxt     = ST_DO;
            end
            CMD_DONT: begin
                s.res.vld = 1'b0;
                s.nxt     = ST_DONT;
            end
            CMD_EOR: begin
                s.res.vld  = cfg.peer_eor;
                s.res.kind = KIND_EOF;
            end
            CMD_EOF:  s.res.kind = KIND_EOF;
            CMD_SUSP: s.res.kind = KIND_SUSP;
            CMD_IAC:  s.res.val  = CMD_IAC;
            default:  s.res.vld  = 1'b0;
        endcase
        return s;
    endfunction

    // next state and results of the byte on the input
    always_comb begin
        t_step             ps;
        t_step             cs;
        logic              sub_ok;
        logic [BYTE_W-1:0] c;
        c         = i_rx_byte;
        ps        = plain_step(c, i_cfg);
        cs        = cmd_step(c, i_cfg);
        sub_ok    = (r_sub_cnt < SubMax);
        n_state   = ST_DATA;
        n_sub_cnt = r_sub_cnt;
        res0      = '{vld: 1'b0, kind: KIND_DATA, val: '0};
        res1      = '{vld: 1'b0, kind: KIND_DATA, val: '0};
        unique case (r_state)
            ST_CR: begin
                if (c != CH_NUL && c != CH_LF) begin
                    res0    = ps.res;
                    n_state = ps.nxt;
                end
            end
            ST_HELD: begin
                if (c == CH_LF) begin
                    res0 = '{vld: 1'b1, kind: KIND_DATA, val: CH_LF};
                end else begin
                    res0 = '{vld: 1'b1, kind: KIND_DATA, val: CH_CR};
                    if (c != CH_NUL) begin
                        res1    = ps.res;
                        n_state = ps.nxt;
                    end
                end
            end
            ST_IAC: begin
                res0    = cs.res;
                n_state = cs.nxt;
                if (cs.sub_clr) begin
                    n_sub_cnt = '0;
                end
            end
            ST_SB: begin
                n_state = ST_SB;
                if (c == CMD_IAC) begin
                    n_state = ST_SE;
                end else if (sub_ok) begin
                    res0      = '{vld: 1'b1, kind: KIND_SUBBYTE, val: c};
                    n_sub_cnt = r_sub_cnt + 1'b1;
                end
            end
            ST_SE: begin
                if (c == CMD_SE) begin
                    res0 = '{vld: 1'b1, kind: KIND_SUBEND, val: '0};
                end else if (c == CMD_IAC) begin
                    n_state = ST_SB;
                    if (sub_ok) begin
                        res0      = '{vld: 1'b1, kind: KIND_SUBBYTE, val: c};
                        n_sub_cnt = r_sub_cnt + 1'b1;
                    end
                end else begin
                    // malformed end: close the subnegotiation, decode as command
                    res0    = '{vld: 1'b1, kind: KIND_SUBEND, val: '0};
                    res1    = cs.res;
                    n_state = cs.nxt;
                    if (cs.sub_clr) begin
                        n_sub_cnt = '0;
                    end
                end
            end
            ST_WILL: res0 = '{vld: 1'b1, kind: KIND_WILL, val: c};
            ST_WONT: res0 = '{vld: 1'b1, kind: KIND_WONT, val: c};
            ST_DO:   res0 = '{vld: 1'b1, kind: KIND_DO,   val: c};
            ST_DONT: res0 = '{vld: 1'b1, kind: KIND_DONT, val: c};
            default: begin
                res0    = ps.res;
                n_state = ps.nxt;
            end
        endcase
    end

    // a second result only ever follows a first one
    assign o_rec_vld   = i_accept & res0.vld;
    assign o_rec.two   = res1.vld;
    assign o_rec.kind0 = res0.kind;
    assign o_rec.val0  = res0.val;
    assign o_rec.kind1 = res1.kind;
    assign o_rec.val1  = res1.val;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_DATA;
            r_sub_cnt <= '0;
        end else if (i_accept) begin
            r_state   <= n_state;
            r_sub_cnt <= n_sub_cnt;
        end
    end

endmodule

// ===== sv/trd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_queue: record queue
// Small FIFO between the parser and the output sequencer so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module trd_queue
    import trd_pkg::*;
#(
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_rec i_wdata,
    input  logic i_rd,
    output t_rec o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PtrLast = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CntFull = CNT_W'(QDEPTH);

    t_rec             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CntFull);
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== sv/trd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_back: output sequencer
// Holds one record in an output register and presents its one or two
// results in order, marking the final one of each input byte.
// ----------------------------------------------------------------------------
module trd_back
    import trd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rec              i_rec,
    input  logic              i_rec_empty,
    output logic              o_rec_rd,
    input  logic              pop,
    output logic              empty,
    output logic [KIND_W-1:0] o_kind,
    output logic [BYTE_W-1:0] o_value,
    output logic              o_last
);

    logic r_valid;
    logic r_idx;
    t_rec r_rec;
    logic xfer, done, load;

    assign xfer     = pop & r_valid;
    assign done     = xfer & (r_idx | ~r_rec.two);
    assign load     = (~r_valid | done) & ~i_rec_empty;
    assign o_rec_rd = load;

    assign empty   = ~r_valid;
    assign o_kind  = r_idx ? r_rec.kind1 : r_rec.kind0;
    assign o_value = r_idx ? r_rec.val1  : r_rec.val0;
    assign o_last  = r_idx | ~r_rec.two;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= 1'b0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else if (xfer) begin
            r_idx   <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
    end

endmodule
